@@ design/fbq_pkg.sv @@
package fbq_pkg;

    localparam int unsigned BASE_W  = 48;
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned TOTAL_W = 38;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned ENTRY_W = BASE_W + SIZE_W + 2;

    localparam logic [SIZE_W-1:0] THRESHOLD_RESET = 32'd100000;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_FORCE     = 1'b1;

    typedef enum logic [1:0] {
        REQ_FREE    = 2'd0,
        REQ_SCAN    = 2'd1,
        REQ_SWEEP   = 2'd2,
        REQ_RELEASE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_QUEUED   = 3'd0,
        ST_FULL     = 3'd1,
        ST_MARKED   = 3'd2,
        ST_NONE     = 3'd3,
        ST_RELEASED = 3'd4,
        ST_DONE     = 3'd5
    } t_code;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_RD,
        S_INS_PROC,
        S_SCAN_RD,
        S_SCAN_PROC,
        S_ACC_RD,
        S_ACC_PROC,
        S_COMMIT,
        S_REL_RD,
        S_REL_PROC,
        S_REL_END,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic  load;
        logic  ins_shift;
        logic  ins_place;
        logic  scan_next;
        logic  scan_hit;
        logic  acc;
        logic  commit;
        logic  rel_step;
        logic  set_code;
        t_code code;
        logic  emit_code;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic full;
        logic due;
        logic end_cnt;
        logic end_lim;
        logic idx_zero;
        logic base_gt;
        logic hit;
        logic releases;
        logic none_emitted;
        logic out_free;
    } t_stat;

endpackage

@@ design/freed_block_quarantine_mark_sweep_core.sv @@
// Quarantine table for freed blocks with mark and sweep reclaim.
// Requests enter on the s_axis channel: tuser carries the request kind
// (free, scan, sweep, release all) and tdata the address, size and heap flag.
// Results leave on the m_axis channel, one word per result; tlast marks the
// final word of a request. A sweep or release all gives one word per released
// block in ascending base order, or a single done word if nothing is freed (a sweep
// that is not due gives one none word). The user writes the two registers
// through the plain write port only while idle; the block itself does not
// enforce this. One request is worked on at a time, and s_axis_tready is high
// only between requests. A free shifts each entry with a higher base up one
// place, a scan visits entries until the hit, a sweep reads the table twice
// (marks, then release) and a release all once, through one read port.
// The result word sits in an output register, so work goes on while it waits;
// a stalled receiver holds the block only when the next word is ready.
// Reset empties the table, clears all marks and loads the register defaults.
module freed_block_quarantine_mark_sweep_core #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // address[47:0], block_size[79:48], iso_heap[80], zero fill
    input  logic [87:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // release_base[47:0], release_iso[48], reclaim_due[49], entry_count[56:50],
    // total_bytes[94:57], zero fill
    output logic [95:0]  m_axis_tdata,
    // status[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import fbq_pkg::*;

    t_cmd                w_cmd;
    t_stat               w_stat;
    logic [BASE_W-1:0]   w_base;
    logic                w_iso;
    logic                w_due;
    logic [COUNT_W-1:0]  w_cnt;
    logic [TOTAL_W-1:0]  w_total;

    fbq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    fbq_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (s_axis_tuser),
        .i_address     (s_axis_tdata[47:0]),
        .i_block_size  (s_axis_tdata[79:48]),
        .i_iso_heap    (s_axis_tdata[80]),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (m_axis_tuser),
        .o_release_base(w_base),
        .o_release_iso (w_iso),
        .o_last        (m_axis_tlast),
        .o_reclaim_due (w_due),
        .o_entry_count (w_cnt),
        .o_total_bytes (w_total)
    );

    assign m_axis_tdata = {1'b0, w_total, w_cnt, w_due, w_iso, w_base};

    a_only_release_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == ST_RELEASED)
        else $error("non-final word that is not a release");

    a_due_needs_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[49] |-> m_axis_tdata[56:50] != '0)
        else $error("reclaim due with an empty table");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[56:50] <= COUNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
endmodule

@@ design/fbq_ram.sv @@
module fbq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/fbq_ctrl.sv @@
module fbq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fbq_pkg::t_stat i_stat,
    output fbq_pkg::t_cmd  o_cmd
);
    import fbq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.code = ST_DONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (i_stat.req) inside
                    REQ_FREE: begin
                        if (i_stat.full) begin
                            o_cmd.set_code = 1'b1;
                            o_cmd.code     = ST_FULL;
                            n_state        = S_EMIT;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end
                    REQ_SCAN, REQ_SWEEP: begin
                        if (!i_stat.due) begin
                            o_cmd.set_code = 1'b1;
                            o_cmd.code     = ST_NONE;
                            n_state        = S_EMIT;
                        end else if (i_stat.req == REQ_SCAN) begin
                            n_state = S_SCAN_RD;
                        end else begin
                            n_state = S_ACC_RD;
                        end
                    end
                    default: begin
                        n_state = S_COMMIT;
                    end
                endcase
            end
            S_INS_RD: begin
                n_state = S_INS_PROC;
            end
            S_INS_PROC: begin
                if (i_stat.idx_zero || !i_stat.base_gt) begin
                    o_cmd.ins_place = 1'b1;
                    o_cmd.set_code  = 1'b1;
                    o_cmd.code      = ST_QUEUED;
                    n_state         = S_EMIT;
                end else begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = S_INS_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.end_cnt) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_NONE;
                    n_state        = S_EMIT;
                end else begin
                    n_state = S_SCAN_PROC;
                end
            end
            S_SCAN_PROC: begin
                if (i_stat.hit) begin
                    o_cmd.scan_hit = 1'b1;
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_MARKED;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_ACC_RD: begin
                n_state = i_stat.end_cnt ? S_COMMIT : S_ACC_PROC;
            end
            S_ACC_PROC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_ACC_RD;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_REL_RD;
            end
            S_REL_RD: begin
                n_state = i_stat.end_lim ? S_REL_END : S_REL_PROC;
            end
            S_REL_PROC: begin
                if (!i_stat.releases || i_stat.out_free) begin
                    o_cmd.rel_step = 1'b1;
                    n_state        = S_REL_RD;
                end
            end
            S_REL_END: begin
                if (i_stat.none_emitted) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_DONE;
                    n_state        = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_code = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

@@ design/fbq_dp.sv @@
module fbq_dp #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [fbq_pkg::SIZE_W-1:0]    i_cfg_data,
    input  logic [1:0]                    i_req_type,
    input  logic [fbq_pkg::BASE_W-1:0]    i_address,
    input  logic [fbq_pkg::SIZE_W-1:0]    i_block_size,
    input  logic                          i_iso_heap,
    input  fbq_pkg::t_cmd                 i_cmd,
    output fbq_pkg::t_stat                o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [2:0]                    o_status,
    output logic [fbq_pkg::BASE_W-1:0]    o_release_base,
    output logic                          o_release_iso,
    output logic                          o_last,
    output logic                          o_reclaim_due,
    output logic [fbq_pkg::COUNT_W-1:0]   o_entry_count,
    output logic [fbq_pkg::TOTAL_W-1:0]   o_total_bytes
);
    import fbq_pkg::*;

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    t_req                r_type;
    logic [BASE_W-1:0]   r_addr;
    logic [SIZE_W-1:0]   r_size;
    logic                r_iso;
    logic [SIZE_W-1:0]   r_thr;
    logic                r_force;
    logic [CW-1:0]       r_count;
    logic [TOTAL_W-1:0]  r_total;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_wp;
    logic [CW-1:0]       r_lim;
    logic [CW-1:0]       r_kcnt;
    logic [TOTAL_W-1:0]  r_ksum;
    logic [CW-1:0]       r_emit;
    t_code               r_code;

    logic                r_ovalid;
    t_code               r_ostat;
    logic [BASE_W-1:0]   r_obase;
    logic                r_oiso;
    logic                r_olast;
    logic                r_odue;
    logic [COUNT_W-1:0]  r_ocnt;
    logic [TOTAL_W-1:0]  r_ototal;

    logic [CW-1:0]       w_prev;
    logic [AW-1:0]       w_ia;
    logic [AW-1:0]       w_pa;
    logic [ENTRY_W-1:0]  w_rdata;
    logic [BASE_W-1:0]   w_rd_base;
    logic [SIZE_W-1:0]   w_rd_size;
    logic                w_rd_iso;
    logic                w_rd_mark;
    logic [BASE_W-1:0]   w_new_base;
    logic [BASE_W:0]     w_end;
    logic                w_hit;
    logic                w_due;
    logic                w_rel;
    logic                w_rel_last;
    logic                w_out_free;
    logic                w_emit_rel;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [ENTRY_W-1:0]  w_wdata;
    logic [AW-1:0]       w_raddr;

    assign w_prev     = r_idx - 1'b1;
    assign w_ia       = r_idx[AW-1:0];
    assign w_pa       = w_prev[AW-1:0];
    assign w_rd_base  = w_rdata[BASE_W-1:0];
    assign w_rd_size  = w_rdata[BASE_W+SIZE_W-1:BASE_W];
    assign w_rd_iso   = w_rdata[ENTRY_W-2];
    assign w_rd_mark  = w_rdata[ENTRY_W-1];
    assign w_new_base = {r_addr[BASE_W-1:2], 2'b00};
    assign w_end      = {1'b0, w_rd_base} + {{(BASE_W+1-SIZE_W){1'b0}}, w_rd_size};
    assign w_hit      = (r_addr >= w_rd_base) && ({1'b0, r_addr} < w_end);
    assign w_due      = (r_count != '0) &&
                        ((r_total >= {{(TOTAL_W-SIZE_W){1'b0}}, r_thr}) || r_force);
    assign w_rel      = (r_type == REQ_RELEASE) || !w_rd_mark;
    assign w_rel_last = (r_emit + 1'b1) == (r_lim - r_count);
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_emit_rel = i_cmd.rel_step && w_rel;
    assign w_raddr    = (r_type == REQ_FREE) ? w_pa : w_ia;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_ia;
        w_wdata = w_rdata;
        if (i_cmd.ins_shift) begin
            w_we = 1'b1;
        end else if (i_cmd.ins_place) begin
            w_we    = 1'b1;
            w_wdata = {1'b0, r_iso, r_size, w_new_base};
        end else if (i_cmd.scan_hit) begin
            w_we    = 1'b1;
            w_wdata = {1'b1, w_rdata[ENTRY_W-2:0]};
        end else if (i_cmd.rel_step && !w_rel) begin
            w_we    = 1'b1;
            w_waddr = r_wp[AW-1:0];
            w_wdata = {1'b0, w_rdata[ENTRY_W-2:0]};
        end
    end

    fbq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_entries (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THRESHOLD_RESET;
            r_force <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_thr   <= i_cfg_data;
                CFG_FORCE:     r_force <= i_cfg_data[0];
                default:       r_force <= r_force;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= t_req'(i_req_type);
            r_addr <= i_address;
            r_size <= i_block_size;
            r_iso  <= i_iso_heap;
        end
        if (i_cmd.set_code) begin
            r_code <= i_cmd.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_idx   <= '0;
            r_wp    <= '0;
            r_lim   <= '0;
            r_kcnt  <= '0;
            r_ksum  <= '0;
            r_emit  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx  <= (t_req'(i_req_type) == REQ_FREE) ? r_count : '0;
                r_wp   <= '0;
                r_kcnt <= '0;
                r_ksum <= '0;
                r_emit <= '0;
            end
            if (i_cmd.ins_shift) begin
                r_idx <= w_prev;
            end
            if (i_cmd.ins_place) begin
                r_count <= r_count + 1'b1;
                r_total <= r_total + {{(TOTAL_W-SIZE_W){1'b0}}, r_size};
            end
            if (i_cmd.scan_next || i_cmd.acc || i_cmd.rel_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.acc && w_rd_mark) begin
                r_kcnt <= r_kcnt + 1'b1;
                r_ksum <= r_ksum + {{(TOTAL_W-SIZE_W){1'b0}}, w_rd_size};
            end
            if (i_cmd.commit) begin
                r_lim   <= r_count;
                r_count <= r_kcnt;
                r_total <= r_ksum;
                r_idx   <= '0;
            end
            if (i_cmd.rel_step) begin
                if (w_rel) begin
                    r_emit <= r_emit + 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_code || w_emit_rel) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_code || w_emit_rel) begin
            r_odue   <= w_due;
            r_ocnt   <= COUNT_W'(r_count);
            r_ototal <= r_total;
            if (w_emit_rel) begin
                r_ostat <= ST_RELEASED;
                r_obase <= w_rd_base;
                r_oiso  <= w_rd_iso;
                r_olast <= w_rel_last;
            end else begin
                r_ostat <= r_code;
                r_obase <= '0;
                r_oiso  <= 1'b0;
                r_olast <= 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.req          = r_type;
        o_stat.full         = r_count == CW'(TABLE_DEPTH);
        o_stat.due          = w_due;
        o_stat.end_cnt      = r_idx == r_count;
        o_stat.end_lim      = r_idx == r_lim;
        o_stat.idx_zero     = r_idx == '0;
        o_stat.base_gt      = w_rd_base > w_new_base;
        o_stat.hit          = w_hit;
        o_stat.releases     = w_rel;
        o_stat.none_emitted = r_emit == '0;
        o_stat.out_free     = w_out_free;
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_ostat;
    assign o_release_base = r_obase;
    assign o_release_iso  = r_oiso;
    assign o_last         = r_olast;
    assign o_reclaim_due  = r_odue;
    assign o_entry_count  = r_ocnt;
    assign o_total_bytes  = r_ototal;
endmodule

@@ test/freed_block_quarantine_mark_sweep_core_tb.sv @@
`timescale 1ns / 100ps

module freed_block_quarantine_mark_sweep_core_tb;
    import fbq_pkg::*;

    localparam int DEPTH = 64;

    typedef struct {
        t_req        req;
        logic [47:0] addr;
        logic [31:0] size;
        logic        iso;
    } req_word_t;

    typedef struct {
        t_code       status;
        logic [47:0] base;
        logic        iso;
        logic        last;
        logic        due;
        logic [6:0]  count;
        logic [37:0] total;
    } result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = CFG_THRESHOLD;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [87:0] s_data = '0;
    logic [1:0]  s_user = REQ_FREE;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [95:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;

    freed_block_quarantine_mark_sweep_core #(.TABLE_DEPTH(DEPTH)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the quarantine table, kept in ascending base order.
    logic [47:0] q_base [DEPTH];
    logic [31:0] q_size [DEPTH];
    logic        q_iso  [DEPTH];
    logic        q_mark [DEPTH];
    int          q_count = 0;
    logic [37:0] q_bytes = '0;
    logic [31:0] q_threshold = THRESHOLD_RESET;
    logic        q_force = 1'b0;

    req_word_t   pending_q[$];
    result_t     expected_q[$];
    int          errors = 0;
    int          words_seen = 0;
    int          releases_seen = 0;
    int          items_sent = 0;
    bit          send_gaps = 1'b0;
    bit          recv_gaps = 1'b0;
    int          recv_hold = 0;

    // Generator-side view of recent frees, used to aim scan words at live blocks.
    logic [47:0] aim_base[$];
    logic [31:0] aim_size[$];

    function automatic bit reclaim_due();
        return q_count != 0 && (q_bytes >= {6'd0, q_threshold} || q_force);
    endfunction

    function automatic result_t mk(t_code code, logic [47:0] base, logic iso);
        result_t r;
        r.status = code;
        r.base = base;
        r.iso = iso;
        r.last = 1'b0;
        r.due = 1'b0;
        r.count = '0;
        r.total = '0;
        return r;
    endfunction

    task automatic release_entries(input bit all, inout result_t outs[$]);
        int kept;
        kept = 0;
        for (int i = 0; i < q_count; i++) begin
            if (all || !q_mark[i]) begin
                outs.push_back(mk(ST_RELEASED, q_base[i], q_iso[i]));
                q_bytes = q_bytes - {6'd0, q_size[i]};
            end else begin
                q_base[kept] = q_base[i];
                q_size[kept] = q_size[i];
                q_iso[kept] = q_iso[i];
                kept++;
            end
        end
        for (int i = 0; i < DEPTH; i++) q_mark[i] = 1'b0;
        q_count = kept;
        if (kept == 0) q_bytes = '0;
        if (outs.size() == 0) outs.push_back(mk(ST_DONE, '0, 1'b0));
    endtask

    task automatic predict_results(input req_word_t w);
        result_t outs[$];
        int pos;
        logic [47:0] base;
        t_code code;
        case (w.req)
            REQ_FREE: begin
                if (q_count >= DEPTH) begin
                    outs.push_back(mk(ST_FULL, '0, 1'b0));
                end else begin
                    base = {w.addr[47:2], 2'b00};
                    pos = q_count;
                    while (pos > 0 && q_base[pos-1] > base) begin
                        q_base[pos] = q_base[pos-1];
                        q_size[pos] = q_size[pos-1];
                        q_iso[pos] = q_iso[pos-1];
                        q_mark[pos] = q_mark[pos-1];
                        pos--;
                    end
                    q_base[pos] = base;
                    q_size[pos] = w.size;
                    q_iso[pos] = w.iso;
                    q_mark[pos] = 1'b0;
                    q_count++;
                    q_bytes = q_bytes + {6'd0, w.size};
                    outs.push_back(mk(ST_QUEUED, '0, 1'b0));
                end
            end
            REQ_SCAN: begin
                code = ST_NONE;
                if (reclaim_due()) begin
                    for (int i = 0; i < q_count; i++) begin
                        if ({16'd0, w.addr} >= {16'd0, q_base[i]} &&
                            {16'd0, w.addr} < {16'd0, q_base[i]} + {32'd0, q_size[i]}) begin
                            q_mark[i] = 1'b1;
                            code = ST_MARKED;
                            break;
                        end
                    end
                end
                outs.push_back(mk(code, '0, 1'b0));
            end
            REQ_SWEEP: begin
                if (reclaim_due()) release_entries(1'b0, outs);
                else outs.push_back(mk(ST_NONE, '0, 1'b0));
            end
            default: release_entries(1'b1, outs);
        endcase
        foreach (outs[k]) begin
            outs[k].last = (k == outs.size() - 1);
            outs[k].due = reclaim_due();
            outs[k].count = q_count[6:0];
            outs[k].total = q_bytes;
            expected_q.push_back(outs[k]);
        end
    endtask

    // Sender.
    int send_wait = 0;
    always @(posedge i_clk) begin
        req_word_t w;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                w.req = t_req'(s_user);
                w.addr = s_data[47:0];
                w.size = s_data[79:48];
                w.iso = s_data[80];
                predict_results(w);
                items_sent++;
            end
            if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                w = pending_q.pop_front();
                s_valid <= 1'b1;
                s_user <= w.req;
                s_data <= {7'd0, w.iso, w.size, w.addr};
                send_wait = (send_gaps && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver and result checker.
    int recv_wait = 0;
    always @(posedge i_clk) begin
        result_t got, exp;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                got.status = t_code'(m_user);
                got.base = m_data[47:0];
                got.iso = m_data[48];
                got.due = m_data[49];
                got.count = m_data[56:50];
                got.total = m_data[94:57];
                got.last = m_last;
                if (got.status == ST_RELEASED) releases_seen++;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word status=%0d base=%h", $time,
                             got.status, got.base);
                end else begin
                    exp = expected_q.pop_front();
                    if (got.status !== exp.status || got.base !== exp.base ||
                        got.iso !== exp.iso || got.last !== exp.last ||
                        got.due !== exp.due || got.count !== exp.count ||
                        got.total !== exp.total) begin
                        errors++;
                        $display("%0t: mismatch expected st=%0d base=%h iso=%b last=%b due=%b cnt=%0d tot=%h",
                                 $time, exp.status, exp.base, exp.iso, exp.last, exp.due,
                                 exp.count, exp.total);
                        $display("%0t:          actual st=%0d base=%h iso=%b last=%b due=%b cnt=%0d tot=%h",
                                 $time, got.status, got.base, got.iso, got.last, got.due,
                                 got.count, got.total);
                    end
                end
                recv_wait = (recv_gaps && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_word(t_req req, logic [47:0] addr, logic [31:0] size, logic iso);
        req_word_t w;
        w.req = req;
        w.addr = addr;
        w.size = size;
        w.iso = iso;
        pending_q.push_back(w);
        if (req == REQ_FREE) begin
            aim_base.push_back({addr[47:2], 2'b00});
            aim_size.push_back(size);
            if (aim_base.size() > 64) begin
                void'(aim_base.pop_front());
                void'(aim_size.pop_front());
            end
        end else if (req == REQ_RELEASE) begin
            aim_base.delete();
            aim_size.delete();
        end
    endtask

    function automatic logic [47:0] rand_addr();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic push_random_word();
        int pick, k;
        logic [47:0] addr;
        logic [31:0] size;
        pick = $urandom_range(0, 99);
        size = $urandom;
        if (pick < 45) begin
            if ($urandom_range(0, 4) != 0)
                addr = 48'({$urandom_range(0, 255), 6'd0} | $urandom_range(0, 3));
            else addr = rand_addr();
            k = $urandom_range(0, 9);
            if (k < 7) size = $urandom_range(1, 2000);
            else if (k == 7) size = '0;
            push_word(REQ_FREE, addr, size, 1'($urandom_range(0, 1)));
        end else if (pick < 80) begin
            addr = rand_addr();
            if (aim_base.size() != 0 && $urandom_range(0, 4) != 0) begin
                k = $urandom_range(0, aim_base.size() - 1);
                addr = aim_base[k];
                if (aim_size[k] != 0) addr = addr + 48'($urandom % aim_size[k]);
            end
            push_word(REQ_SCAN, addr, size, 1'($urandom_range(0, 1)));
        end else if (pick < 93) begin
            push_word(REQ_SWEEP, rand_addr(), size, 1'($urandom_range(0, 1)));
        end else begin
            push_word(REQ_RELEASE, rand_addr(), size, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || s_valid || expected_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD) q_threshold = value;
        else q_force = value[0];
    endtask

    task automatic random_phase(logic [31:0] thr, logic frc, int n);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_FORCE, {31'd0, frc});
        send_gaps = 1'($urandom_range(0, 1));
        recv_gaps = 1'($urandom_range(0, 1));
        repeat (n) push_random_word();
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < DEPTH; i++) q_mark[i] = 1'b0;

        // Directed part, register defaults first.
        push_word(REQ_SCAN, 48'h1000, '0, 1'b0);
        push_word(REQ_SWEEP, '0, '0, 1'b0);
        push_word(REQ_RELEASE, '0, '0, 1'b0);
        push_word(REQ_FREE, 48'h1003, 32'd0, 1'b0);
        push_word(REQ_FREE, 48'h1000, 32'h100, 1'b1);
        push_word(REQ_FREE, 48'h800, 32'd50, 1'b0);
        push_word(REQ_SCAN, 48'h1000, '0, 1'b0);
        push_word(REQ_FREE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_word(REQ_SCAN, 48'h1000, '0, 1'b0);
        push_word(REQ_SCAN, 48'h1000, '0, 1'b0);
        push_word(REQ_SCAN, 48'h5, '0, 1'b0);
        push_word(REQ_FREE, 48'h1010, 32'h20, 1'b0);
        push_word(REQ_SCAN, 48'h1018, 32'hFFFF_FFFF, 1'b1);
        push_word(REQ_SWEEP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_word(REQ_SWEEP, '0, '0, 1'b0);
        push_word(REQ_RELEASE, '0, '0, 1'b0);
        push_word(REQ_RELEASE, '0, '0, 1'b0);
        wait_idle();
        write_reg(CFG_FORCE, 32'd1);
        push_word(REQ_FREE, 48'h40, 32'd8, 1'b1);
        push_word(REQ_SWEEP, '0, '0, 1'b0);
        push_word(REQ_FREE, 48'h80, 32'd16, 1'b0);
        push_word(REQ_SCAN, 48'h8F, '0, 1'b0);
        push_word(REQ_SWEEP, '0, '0, 1'b0);
        push_word(REQ_SWEEP, '0, '0, 1'b0);
        push_word(REQ_RELEASE, '0, '0, 1'b0);
        wait_idle();

        // Fill the table past its depth while the receiver holds off.
        write_reg(CFG_THRESHOLD, 32'd0);
        write_reg(CFG_FORCE, 32'd0);
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        for (int i = 0; i < DEPTH + 3; i++)
            push_word(REQ_FREE, 48'({$urandom_range(0, 63), 8'd0} | $urandom_range(0, 3)),
                      $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        repeat (20) push_random_word();
        push_word(REQ_RELEASE, '0, '0, 1'b0);
        recv_hold = 400;
        wait_idle();

        random_phase(THRESHOLD_RESET, 1'b0, 70);
        random_phase(32'd0, 1'b0, 70);
        random_phase(32'hFFFF_FFFF, 1'b0, 50);
        random_phase(32'hFFFF_FFFF, 1'b1, 60);
        random_phase(32'd5000, 1'b1, 60);
        random_phase(32'd20000, 1'b0, 60);

        repeat (200) @(negedge i_clk);
        if (expected_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, expected_q.size());
        end
        $display("Sent %0d requests, checked %0d result words (%0d block releases),",
                 items_sent, words_seen, releases_seen);
        $display("over seven threshold and force settings including a full table.");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
